FILE: src/pcpt_pkg.sv
// Package for the per-core progress table: opcodes, field widths, state codes.
// No dependencies.
package pcpt_pkg;
   localparam int OpW = 3;
   localparam logic [OpW-1:0] OP_INIT_DIRECT  = 3'd0;
   localparam logic [OpW-1:0] OP_INIT_CHUNKED = 3'd1;
   localparam logic [OpW-1:0] OP_INIT_EVEN    = 3'd2;
   localparam logic [OpW-1:0] OP_POST         = 3'd3;
   localparam logic [OpW-1:0] OP_READ         = 3'd4;
   localparam logic [23:0] FRAC_MAX = 24'hFFFFFF;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_RD, ST_DIV1, ST_DIV1W, ST_DIV2, ST_DIV2W, ST_CALC,
      ST_WB, ST_RESP
   } state_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;
endpackage

FILE: src/pcpt_div.sv
// Radix-2 restoring divider: 64-bit dividend by 32-bit divisor, one bit a cycle.
// Depends on pcpt_pkg. Divisor must be nonzero.
module pcpt_div import pcpt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output logic        busy,
   output logic [63:0] quotient,
   output logic [31:0] remainder
);
   logic [63:0] q_ff, q_in;
   logic [32:0] r_ff, r_in;
   logic [31:0] d_ff, d_in;
   logic [6:0]  n_ff, n_in;
   logic [32:0] trial;

   // Shift one dividend bit into the partial remainder per cycle
   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; n_in = n_ff;
      trial = {r_ff[31:0], q_ff[63]} - {1'b0, d_ff};
      if (req.start) begin
         q_in = req.dividend; r_in = '0; d_in = req.divisor; n_in = 7'd64;
      end else if (n_ff != 7'd0) begin
         n_in = n_ff - 7'd1;
         if (!trial[32]) begin
            r_in = trial; q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = {r_ff[31:0], q_ff[63]}; q_in = {q_ff[62:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) n_ff <= '0;
      else n_ff <= n_in;
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
   end

   assign busy = (n_ff != 7'd0);
   assign quotient = q_ff;
   assign remainder = r_ff[31:0];

`ifndef SYNTHESIS
   a_count: assert property (@(posedge clock) disable iff (reset)
      (n_ff != 7'd0 && !req.start) |=> n_ff == $past(n_ff) - 7'd1)
      else $error("divider count skipped");
   a_start: assert property (@(posedge clock) disable iff (reset)
      req.start |=> busy) else $error("divider did not start");
   a_rem: assert property (@(posedge clock) disable iff (reset)
      busy |-> r_ff <= {1'b0, d_ff}) else $error("remainder out of range");
`endif
endmodule

FILE: src/per_core_progress_table.sv
// Top level of the per-core progress table: request FSM, entry memory, divider.
// Depends on pcpt_pkg and pcpt_div.
//
// channel | direction | handshake          | word
// req_    | in        | tvalid/tready      | tuser opcode, tdata request fields
// rsp_    | out       | tvalid/tready      | tdata result fields
// csr_    | in        | valid/ready        | enable bit
//
// Init chunked takes two 64-step divisions, init even one and read at most one,
// done by the one-bit-per-cycle divider; post and direct init take none. After
// reset a clearing pass zeroes all CPUS entries of the memory, with req_tready
// low. A stalled rsp_ holds the word.
module per_core_progress_table import pcpt_pkg::*; #(
   parameter int CPUS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: cpu_index[5:0], work_units[37:6], thread_count[53:38],
   // thread_index[69:54], iteration_count[101:70], chunk_len[133:102], pad
   input  logic [135:0] req_tdata,
   // tuser: opcode[2:0]
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: done_count[31:0], work_total[63:32], progress_fraction[87:64],
   // no_total[88], saturated[89], pad
   output logic [95:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [0:0]   csr_data
);
   localparam int AW = (CPUS > 1) ? $clog2(CPUS) : 1;

   state_type state_ff, state_in;
   logic enable_ff;
   logic [63:0] mem [CPUS];
   logic [63:0] rd_ff;
   logic [AW-1:0] addr_ff, addr_in;
   logic [2:0]  op_ff;
   logic        valid_ff;
   logic [31:0] units_ff, thr_ff, tix_ff, iter_ff, chunk_ff;
   logic [31:0] q1_ff, r1_ff;
   logic [31:0] cnt_ff, cnt_in, tot_ff, tot_in;
   logic [23:0] frac_ff;
   logic        nt_ff, sat_ff;
   logic        we;
   div_req_type dreq;
   logic        dbusy;
   logic [63:0] dq;
   logic [31:0] dr;
   logic [5:0]  cpu_raw;

   assign cpu_raw = req_tdata[5:0];
   assign csr_ready = 1'b1;

   pcpt_div u_div (.clock, .reset, .req(dreq), .busy(dbusy), .quotient(dq),
      .remainder(dr));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (addr_ff == AW'(CPUS - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (req_tvalid) state_in = ST_RD;
         ST_RD: begin
            if (op_ff == OP_INIT_CHUNKED || op_ff == OP_INIT_EVEN) state_in = ST_DIV1;
            else state_in = ST_CALC;
         end
         ST_DIV1:  state_in = ST_DIV1W;
         ST_DIV1W: if (!dbusy)
            state_in = (op_ff == OP_INIT_CHUNKED) ? ST_DIV2 : ST_CALC;
         ST_DIV2:  state_in = ST_DIV2W;
         ST_DIV2W: if (!dbusy) state_in = ST_CALC;
         ST_CALC: begin
            if (op_ff == OP_READ && valid_ff && rd_ff[63:32] != 32'd0) state_in = ST_DIV1;
            else state_in = ST_WB;
         end
         ST_WB:    state_in = ST_RESP;
         ST_RESP:  if (rsp_tready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
      // read divide finishes in DIV1W then goes to WB via CALC skip
      if (state_ff == ST_DIV1W && !dbusy && op_ff == OP_READ) state_in = ST_WB;
   end

   // Outputs of the sequencer
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_RESP);
      dreq = '0;
      if (state_ff == ST_DIV1) begin
         dreq.start = 1'b1;
         if (op_ff == OP_READ) begin
            dreq.dividend = {16'd0, rd_ff[31:0], 16'd0};
            dreq.divisor  = rd_ff[63:32];
         end else if (op_ff == OP_INIT_CHUNKED) begin
            dreq.dividend = {32'd0, iter_ff};
            dreq.divisor  = chunk_ff;
         end else begin
            dreq.dividend = {32'd0, iter_ff};
            dreq.divisor  = thr_ff;
         end
      end else if (state_ff == ST_DIV2) begin
         dreq.start    = 1'b1;
         dreq.dividend = {32'd0, q1_ff};
         dreq.divisor  = thr_ff;
      end
   end

   // Share arithmetic and table update values
   always_comb begin
      logic [31:0] share;
      logic [31:0] base;
      cnt_in = cnt_ff; tot_in = tot_ff; share = '0; base = '0;
      addr_in = addr_ff;
      if (state_ff == ST_CLEAR) addr_in = addr_ff + AW'(1);
      if (state_ff == ST_IDLE) addr_in = AW'(cpu_raw);
      if (state_ff == ST_CALC) begin
         if (op_ff == OP_INIT_CHUNKED) begin
            base = dq[31:0] * chunk_ff;
            if (tix_ff < {16'd0, dr[15:0]} && dr[31:16] == 16'd0 || tix_ff < dr)
               share = base[31:0] + chunk_ff;
            else if (tix_ff == dr) share = base[31:0] + r1_ff;
            else share = base[31:0];
         end else if (op_ff == OP_INIT_EVEN) begin
            share = q1_ff + ((tix_ff < dr) ? 32'd1 : 32'd0);
         end else share = units_ff;
         if (op_ff != OP_INIT_DIRECT && tix_ff >= thr_ff) share = '0;
         cnt_in = valid_ff ? rd_ff[31:0] : 32'd0;
         tot_in = valid_ff ? rd_ff[63:32] : 32'd0;
         if (valid_ff && enable_ff) begin
            if (op_ff == OP_INIT_DIRECT || op_ff == OP_INIT_CHUNKED ||
                op_ff == OP_INIT_EVEN) begin
               cnt_in = '0; tot_in = share;
            end else if (op_ff == OP_POST) cnt_in = rd_ff[31:0] + 32'd1;
         end
      end
   end

   assign we = (state_ff == ST_CLEAR) || (state_ff == ST_WB && valid_ff && enable_ff);

   // Entry memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (we) mem[addr_ff] <= (state_ff == ST_CLEAR) ? 64'd0 : {tot_ff, cnt_ff};
      rd_ff <= mem[addr_in];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         addr_ff   <= '0;
         enable_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         if (csr_valid) enable_ff <= csr_data[0];
      end
   end

   // Capture request and intermediate results
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_tvalid) begin
         op_ff    <= req_tuser;
         valid_ff <= (32'(cpu_raw) < CPUS);
         units_ff <= req_tdata[37:6];
         thr_ff   <= (req_tdata[53:38] == 16'd0) ? 32'd1 : {16'd0, req_tdata[53:38]};
         tix_ff   <= {16'd0, req_tdata[69:54]};
         iter_ff  <= req_tdata[101:70];
         chunk_ff <= (req_tdata[133:102] == 32'd0) ? 32'd1 : req_tdata[133:102];
         frac_ff  <= '0; nt_ff <= 1'b0; sat_ff <= 1'b0;
      end
      if (state_ff == ST_DIV1W && !dbusy) begin
         q1_ff <= dq[31:0]; r1_ff <= dr;
         if (op_ff == OP_READ) begin
            if (dq[63:24] != 40'd0) begin
               frac_ff <= FRAC_MAX; sat_ff <= 1'b1;
            end else frac_ff <= dq[23:0];
         end
      end
      if (state_ff == ST_CALC) begin
         cnt_ff <= cnt_in; tot_ff <= tot_in;
         if (op_ff == OP_READ && (!valid_ff || rd_ff[63:32] == 32'd0)) nt_ff <= 1'b1;
      end
   end

   assign rsp_tdata = {6'd0, sat_ff, nt_ff, frac_ff, tot_ff, cnt_ff};

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("response changed while stalled");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("accept during response");
   a_nt: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(nt_ff && sat_ff)) else $error("no_total with saturation");
`endif
endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for per_core_progress_table: drives request words,
// predicts each result from a local model of the table and compares.
// Depends on pcpt_pkg and the per_core_progress_table RTL.
module testbench;
   import pcpt_pkg::*;

   localparam int NCPU = 64;
   localparam longint CYCLE_LIMIT = 64'd4_000_000;

   // packed from the top bit down, so done_count lands in the lowest bits
   typedef struct packed {
      logic        saturated;
      logic        no_total;
      logic [23:0] progress_fraction;
      logic [31:0] work_total;
      logic [31:0] done_count;
   } progress_rsp_t;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [135:0]  req_tdata = '0;
   logic [2:0]    req_tuser = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [95:0]   rsp_tdata;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [0:0]    csr_data = '0;

   // model copy of the table and the enable register
   logic [31:0]   model_done [NCPU];
   logic [31:0]   model_total [NCPU];
   logic          model_enable;
   progress_rsp_t pending_rsp [$];

   int            fail_count = 0;
   int            rsp_seen = 0;
   int            req_sent = 0;
   longint        cycle_count = 0;
   bit            hold_rsp = 1'b0;
   bit            idle_on = 1'b1;

   per_core_progress_table #(.CPUS(NCPU)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[per_core_progress_table] ERROR");
         $finish;
      end
   end

   function automatic logic [31:0] chunk_share(logic [15:0] thr, logic [15:0] idx,
                                               logic [31:0] iter, logic [31:0] chk);
      logic [63:0] t, c, nchunks, rest, base, k;
      t = (thr == 0) ? 64'd1 : 64'(thr);
      c = (chk == 0) ? 64'd1 : 64'(chk);
      if (64'(idx) >= t) return 32'd0;
      nchunks = 64'(iter) / c;
      rest = 64'(iter) % c;
      base = c * (nchunks / t);
      k = nchunks % t;
      if (64'(idx) < k) base = base + c;
      else if (64'(idx) == k) base = base + rest;
      return base[31:0];
   endfunction

   function automatic logic [31:0] even_share(logic [15:0] thr, logic [15:0] idx,
                                              logic [31:0] iter);
      logic [63:0] t, s;
      t = (thr == 0) ? 64'd1 : 64'(thr);
      if (64'(idx) >= t) return 32'd0;
      s = 64'(iter) / t;
      if (64'(idx) < 64'(iter) % t) s = s + 1;
      return s[31:0];
   endfunction

   // update the table model and queue the expected word
   task automatic predict_progress(logic [2:0] op, logic [5:0] cpu, logic [31:0] units,
                                   logic [15:0] thr, logic [15:0] idx,
                                   logic [31:0] iter, logic [31:0] chk);
      progress_rsp_t r;
      logic [63:0] q;
      r = '0;
      if (model_enable) begin
         case (op)
            OP_INIT_DIRECT: begin
               model_done[cpu] = 0; model_total[cpu] = units;
            end
            OP_INIT_CHUNKED: begin
               model_done[cpu] = 0; model_total[cpu] = chunk_share(thr, idx, iter, chk);
            end
            OP_INIT_EVEN: begin
               model_done[cpu] = 0; model_total[cpu] = even_share(thr, idx, iter);
            end
            OP_POST: model_done[cpu] = model_done[cpu] + 32'd1;
            default: ;
         endcase
      end
      r.done_count = model_done[cpu];
      r.work_total = model_total[cpu];
      if (op == OP_READ) begin
         if (r.work_total == 0) begin
            r.no_total = 1'b1;
         end else begin
            q = {r.done_count, 16'd0} / 64'(r.work_total);
            if (q > 64'(FRAC_MAX)) begin
               r.progress_fraction = FRAC_MAX; r.saturated = 1'b1;
            end else begin
               r.progress_fraction = q[23:0];
            end
         end
      end
      pending_rsp.push_back(r);
   endtask

   // send one request word, with an optional random gap first
   task automatic send_request(logic [2:0] op, logic [5:0] cpu, logic [31:0] units,
                               logic [15:0] thr, logic [15:0] idx,
                               logic [31:0] iter, logic [31:0] chk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_tuser <= op;
      req_tdata <= {2'b00, chk, iter, idx, thr, units, cpu};
      req_tvalid <= 1'b1;
      predict_progress(op, cpu, units, thr, idx, iter, chk);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      req_sent++;
      @(negedge clock);
   endtask

   task automatic drop_valid();
      req_tvalid <= 1'b0;
   endtask

   // wait out outstanding words before touching the register
   task automatic drain_table();
      drop_valid();
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (160) @(negedge clock);
   endtask

   task automatic write_enable(logic en);
      drain_table();
      csr_data <= en;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      model_enable = en;
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(0, 20);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [15:0] rand_half();
      case ($urandom_range(0, 4))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(0, 9));
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic test_directed();
      send_request(OP_READ, 6'd0, 0, 0, 0, 0, 0);
      send_request(OP_INIT_DIRECT, 6'd63, 32'hFFFF_FFFF, 0, 0, 0, 0);
      send_request(OP_POST, 6'd63, 0, 0, 0, 0, 0);
      send_request(OP_READ, 6'd63, 0, 0, 0, 0, 0);
      // posts past the total: a direct init of one unit, then three posts and a read
      send_request(OP_INIT_DIRECT, 6'd1, 32'd1, 0, 0, 0, 0);
      send_request(OP_POST, 6'd1, 0, 0, 0, 0, 0);
      send_request(OP_POST, 6'd1, 0, 0, 0, 0, 0);
      send_request(OP_POST, 6'd1, 0, 0, 0, 0, 0);
      send_request(OP_READ, 6'd1, 0, 0, 0, 0, 0);
      // chunked: zero thread count and chunk size, index out of range, max fields
      send_request(OP_INIT_CHUNKED, 6'd2, 0, 16'd0, 16'd0, 32'd100, 32'd0);
      send_request(OP_INIT_CHUNKED, 6'd3, 0, 16'd4, 16'd4, 32'd100, 32'd7);
      send_request(OP_INIT_CHUNKED, 6'd4, 0, 16'd4, 16'd2, 32'd100, 32'd7);
      send_request(OP_INIT_CHUNKED, 6'd5, 0, 16'hFFFF, 16'hFFFE,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_INIT_EVEN, 6'd6, 0, 16'd0, 16'd0, 32'hFFFF_FFFF, 0);
      send_request(OP_INIT_EVEN, 6'd7, 0, 16'd3, 16'd1, 32'd10, 0);
      send_request(OP_INIT_EVEN, 6'd8, 0, 16'hFFFF, 16'hFFFF, 32'd10, 0);
      send_request(OP_READ, 6'd4, 0, 0, 0, 0, 0);
      // unused opcodes
      send_request(3'd5, 6'd4, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(3'd6, 6'd4, 0, 0, 0, 0, 0);
      send_request(3'd7, 6'd4, 0, 0, 0, 0, 0);
      send_request(OP_READ, 6'd4, 0, 0, 0, 0, 0);
      // disabled: init and post ignored
      write_enable(1'b0);
      send_request(OP_INIT_DIRECT, 6'd4, 32'd5, 0, 0, 0, 0);
      send_request(OP_POST, 6'd4, 0, 0, 0, 0, 0);
      send_request(OP_READ, 6'd4, 0, 0, 0, 0, 0);
      write_enable(1'b1);
   endtask

   // mostly init / post / read sequences on few entries, some noise
   task automatic test_random(int count);
      logic [5:0] cpu;
      for (int i = 0; i < count; i++) begin
         cpu = ($urandom_range(0, 3) == 0) ? 6'($urandom()) : 6'($urandom_range(0, 7));
         case ($urandom_range(0, 9))
            0: send_request(OP_INIT_DIRECT, cpu, rand_word(), rand_half(), rand_half(),
                            rand_word(), rand_word());
            1: send_request(OP_INIT_CHUNKED, cpu, rand_word(), rand_half(), rand_half(),
                            rand_word(), rand_word());
            2: send_request(OP_INIT_EVEN, cpu, rand_word(), rand_half(), rand_half(),
                            rand_word(), rand_word());
            3, 4, 5: send_request(OP_POST, cpu, $urandom(), rand_half(), rand_half(),
                                  $urandom(), $urandom());
            6, 7, 8: send_request(OP_READ, cpu, $urandom(), rand_half(), rand_half(),
                                  $urandom(), $urandom());
            default: send_request(3'($urandom_range(5, 7)), cpu, $urandom(),
                                  16'($urandom()), 16'($urandom()), $urandom(),
                                  $urandom());
         endcase
      end
   endtask

   // small totals so reads sweep the fraction range, including done counts above the total
   task automatic test_fraction_sweep();
      logic [5:0] cpu;
      for (int i = 0; i < 20; i++) begin
         cpu = 6'(10 + i);
         send_request(OP_INIT_DIRECT, cpu, $urandom_range(1, 3), 0, 0, 0, 0);
         repeat ($urandom_range(0, 6)) send_request(OP_POST, cpu, 0, 0, 0, 0, 0);
         send_request(OP_READ, cpu, 0, 0, 0, 0, 0);
      end
   endtask

   // receiver holds off long while requests keep coming
   task automatic test_backpressure();
      hold_rsp = 1'b1;
      fork
         begin
            repeat (3000) @(negedge clock);
            hold_rsp = 1'b0;
         end
         for (int i = 0; i < 12; i++) send_request(OP_POST, 6'd9, 0, 0, 0, 0, 0);
      join
   endtask

   // response ready with random bursts of stall
   initial begin
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            @(negedge clock);
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // compare each accepted word with the oldest expectation
   always @(posedge clock) begin
      progress_rsp_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[89:0];
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            $error("unexpected word %h", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (got.done_count !== want.done_count) begin
               $error("done_count exp %h got %h", want.done_count, got.done_count);
               fail_count++;
            end
            if (got.work_total !== want.work_total) begin
               $error("work_total exp %h got %h", want.work_total, got.work_total);
               fail_count++;
            end
            if (got.progress_fraction !== want.progress_fraction) begin
               $error("progress_fraction exp %h got %h", want.progress_fraction,
                      got.progress_fraction);
               fail_count++;
            end
            if (got.no_total !== want.no_total) begin
               $error("no_total exp %b got %b", want.no_total, got.no_total);
               fail_count++;
            end
            if (got.saturated !== want.saturated) begin
               $error("saturated exp %b got %b", want.saturated, got.saturated);
               fail_count++;
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < NCPU; i++) begin
         model_done[i] = 0;
         model_total[i] = 0;
      end
      model_enable = 1'b1;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_fraction_sweep();
      test_backpressure();
      test_random(350);
      write_enable(1'b0);
      test_random(60);
      write_enable(1'b1);
      idle_on = 1'b0;
      test_random(300);
      drain_table();
      if (pending_rsp.size() != 0) fail_count++;
      $display("Sent %0d requests (all opcodes, enable on and off, long response stall);",
               req_sent);
      $display("checked %0d result words.", rsp_seen);
      if (fail_count == 0) begin
         $display("[per_core_progress_table] OK");
      end else begin
         $display("[per_core_progress_table] ERROR");
      end
      $finish;
   end
endmodule
